>>> design/spq_pkg.sv
// shared types and constants for the sorted priority queue
package spq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 7;

  typedef enum logic [1:0] {
    StDone     = 2'd0,
    StFull     = 2'd1,
    StEmpty    = 2'd2,
    StNotFound = 2'd3
  } spq_status_e;

  typedef enum logic {
    ActInsert = 1'b0,
    ActDelete = 1'b1
  } spq_action_e;

  typedef struct packed {
    logic                     valid;
    logic signed [ValueW-1:0] value;
  } spq_slot_t;

  typedef struct packed {
    logic                     ins_en;
    logic                     del_en;
    logic signed [ValueW-1:0] value;
  } spq_op_t;

endpackage

>>> design/sorted_priority_queue_top.sv
// sorted priority queue: a chain of compare-and-shift cells with a registered result
//
// Input channel (in_valid_i/in_ready_o) carries action_i and value_i; action 0
// inserts value_i after any equal entries, action 1 removes the first equal entry.
// Output channel (out_valid_o/out_ready_i) returns one result per transfer:
// status_o, count_o (entries after the item) and smallest_o (0 when empty).
// Every cell compares its entry with the broadcast value in the same cycle and
// moves data one slot up or down, so the whole chain updates at the same clock edge.
// out_valid_o rises in the cycle after the input transfer; the queue takes one
// item per cycle while the receiver keeps out_ready_i high.
// When the receiver stalls, the result stays in the output register and
// in_ready_o drops until it is taken; nothing is lost or repeated.
// Reset empties the queue (all slot valid bits and the count go low) and
// drops out_valid_o; entry values and the held result fields are not reset.
// A full queue refuses inserts with status full; a delete on an empty queue or
// with no match leaves the queue unchanged and reports empty or not found.
module sorted_priority_queue_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             action_i,
  input  logic signed [spq_pkg::ValueW-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       status_o,
  output logic [spq_pkg::CountW-1:0]       count_o,
  output logic signed [spq_pkg::ValueW-1:0] smallest_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  spq_slot_t   slot  [DEPTH];
  logic        shift [DEPTH];
  logic [DEPTH-1:0] match;
  spq_op_t     op;
  logic        accept, found, full, empty, is_del;
  spq_status_e status_d;
  spq_status_e status_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic        out_valid_q;
  logic signed [ValueW-1:0] small_q, small_d, small_next;
  logic [CntW+CountW-1:0] cnt_ext;

  assign accept = in_valid_i && in_ready_o;
  assign is_del = (action_i == ActDelete);
  assign found  = |match;
  assign full   = slot[DEPTH-1].valid;
  assign empty  = !slot[0].valid;

  assign op.ins_en = accept && !is_del && !full;
  assign op.del_en = accept && is_del && found;
  assign op.value  = value_i;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    spq_slot_t left_s, right_s;
    logic      left_shift;
    if (k == 0) begin : g_first
      assign left_s.valid = 1'b1;
      assign left_s.value = value_i;
      assign left_shift   = 1'b0;
    end else begin : g_mid
      assign left_s     = slot[k-1];
      assign left_shift = shift[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_s.valid = 1'b0;
      assign right_s.value = '0;
    end else begin : g_inner
      assign right_s = slot[k+1];
    end
    spq_cell u_cell (
      .clk_i,
      .rst_ni,
      .op_i        (op),
      .left_i      (left_s),
      .left_shift_i(left_shift),
      .right_i     (right_s),
      .slot_o      (slot[k]),
      .shift_o     (shift[k]),
      .match_o     (match[k])
    );
  end

  always_comb begin
    cnt_d      = cnt_q;
    small_next = slot[0].value;
    if (is_del) begin
      if (empty) begin
        status_d = StEmpty;
      end else if (!found) begin
        status_d = StNotFound;
      end else begin
        status_d   = StDone;
        cnt_d      = cnt_q - CntW'(1);
        small_next = match[0] ? slot[1].value : slot[0].value;
      end
    end else begin
      if (full) begin
        status_d = StFull;
      end else begin
        status_d   = StDone;
        cnt_d      = cnt_q + CntW'(1);
        small_next = shift[0] ? value_i : slot[0].value;
      end
    end
    small_d = (cnt_d == '0) ? '0 : small_next;
  end

  assign in_ready_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      small_q  <= small_d;
    end
  end

  assign cnt_ext     = {{CountW{1'b0}}, cnt_q};
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign count_o     = cnt_ext[CountW-1:0];
  assign smallest_o  = small_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("count above depth");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot[0].valid == (cnt_q != '0))
    else $error("head slot valid disagrees with count");

  a_tail_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot[DEPTH-1].valid == (cnt_q == CntW'(DEPTH)))
    else $error("last slot valid disagrees with count");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_del && !full) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("accepted insert did not grow the queue");

endmodule

>>> design/spq_cell.sv
// one slot of the sorted chain: compares against the broadcast value and shifts with neighbors
module spq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spq_pkg::spq_op_t   op_i,
  input  spq_pkg::spq_slot_t left_i,
  input  logic               left_shift_i,
  input  spq_pkg::spq_slot_t right_i,
  output spq_pkg::spq_slot_t slot_o,
  output logic               shift_o,
  output logic               match_o
);
  import spq_pkg::*;

  logic                     valid_q, valid_d;
  logic signed [ValueW-1:0] value_q, value_d;
  logic                     at_or_above;

  // insert moves this slot when it is empty or holds a larger value
  assign shift_o     = !valid_q || (op_i.value < value_q);
  assign match_o     = valid_q && (value_q == op_i.value);
  assign at_or_above = valid_q && !(value_q < op_i.value);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (op_i.ins_en && shift_o) begin
      valid_d = valid_q | left_i.valid;
      value_d = left_shift_i ? left_i.value : op_i.value;
    end else if (op_i.del_en && at_or_above) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign slot_o.valid = valid_q;
  assign slot_o.value = value_q;

endmodule

>>> bench/sorted_priority_queue_checker.sv
`timescale 1ns / 1ps
// checker: watches both channels, predicts each result and compares it field by field
module sorted_priority_queue_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic                              action_i,
  input  logic signed [spq_pkg::ValueW-1:0] value_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [1:0]                        status_i,
  input  logic [spq_pkg::CountW-1:0]        count_i,
  input  logic signed [spq_pkg::ValueW-1:0] smallest_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  import spq_pkg::*;

  typedef struct packed {
    spq_status_e              status;
    logic [CountW-1:0]        count;
    logic signed [ValueW-1:0] smallest;
  } queue_result_t;

  logic signed [ValueW-1:0] sorted_values[$];
  queue_result_t            awaited_results[$];
  queue_result_t            oldest;
  int                       fails = 0;
  int                       pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  task automatic report_mismatch(input string field, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    fails++;
  endtask

  // ordered insert after equal entries, or removal of the first equal entry
  function automatic queue_result_t apply_operation(input spq_action_e act,
                                                    input logic signed [ValueW-1:0] v);
    queue_result_t r;
    int            pos;
    r.status = StDone;
    if (act == ActInsert) begin
      if (sorted_values.size() >= DEPTH) begin
        r.status = StFull;
      end else begin
        pos = sorted_values.size();
        for (int k = 0; k < sorted_values.size(); k++) begin
          if (v < sorted_values[k]) begin
            pos = k;
            break;
          end
        end
        sorted_values.insert(pos, v);
      end
    end else begin
      if (sorted_values.size() == 0) begin
        r.status = StEmpty;
      end else begin
        pos = -1;
        for (int k = 0; k < sorted_values.size(); k++) begin
          if (sorted_values[k] == v) begin
            pos = k;
            break;
          end
        end
        if (pos < 0) r.status = StNotFound;
        else sorted_values.delete(pos);
      end
    end
    r.count    = CountW'(sorted_values.size());
    r.smallest = (sorted_values.size() != 0) ? sorted_values[0] : '0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sorted_values.delete();
      awaited_results.delete();
      pending <= 0;
    end else begin
      // result transfer first: it belongs to an earlier input transfer
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("results pending", 1, 0);
        end else begin
          oldest = awaited_results.pop_front();
          if (status_i != oldest.status) report_mismatch("status", oldest.status, status_i);
          if (count_i != oldest.count) report_mismatch("count", oldest.count, count_i);
          if (smallest_i != oldest.smallest)
            report_mismatch("smallest", oldest.smallest, smallest_i);
        end
      end
      if (in_valid_i && in_ready_i)
        awaited_results.push_back(apply_operation(spq_action_e'(action_i), value_i));
      pending <= awaited_results.size();
    end
  end

endmodule

>>> bench/sorted_priority_queue_top_tb.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, operation stimulus, result backpressure and verdict
module sorted_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int unsigned Depth = 64;
  localparam int unsigned PoolSize = 16;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid;
  logic                      in_ready;
  logic                      action;
  logic signed [ValueW-1:0]  value;
  logic                      out_valid;
  logic                      out_ready;
  logic [1:0]                status;
  logic [CountW-1:0]         count;
  logic signed [ValueW-1:0]  smallest;
  int                        fail_count;
  int                        pending;
  bit                        idle_en = 1'b1;
  int                        rx_hold = 0;
  logic signed [ValueW-1:0]  value_pool [PoolSize];

  sorted_priority_queue_top #(.DEPTH(Depth)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .action_i    (action),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .count_o     (count),
    .smallest_o  (smallest)
  );

  sorted_priority_queue_checker #(.DEPTH(Depth)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .action_i     (action),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .status_i     (status),
    .count_i      (count),
    .smallest_i   (smallest),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ready <= !(idle_en && ($urandom_range(0, 99) < 17));
      end
    end
  end

  task automatic send_item(input spq_action_e act, input logic signed [ValueW-1:0] v);
    @(negedge clk_i);
    while (idle_en && ($urandom_range(0, 99) < 17)) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= v;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // pool values make duplicates and delete hits common
  task automatic run_phase(input int n, input int insert_pct, input int pool_pct);
    spq_action_e              act;
    logic signed [ValueW-1:0] v;
    for (int i = 0; i < n; i++) begin
      act = ($urandom_range(0, 99) < insert_pct) ? ActInsert : ActDelete;
      if ($urandom_range(0, 99) < pool_pct) v = value_pool[$urandom_range(0, PoolSize - 1)];
      else v = $urandom;
      send_item(act, v);
    end
  endtask

  initial begin
    in_valid = 1'b0;
    action   = ActInsert;
    value    = '0;
    rst_ni   = 1'b0;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 32'sh0000_0000;
    value_pool[3] = 32'shffff_ffff;
    for (int i = 4; i < PoolSize; i++) value_pool[i] = $urandom;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(ActDelete, 32'sh0000_0005);
    send_item(ActInsert, 32'sh0000_0000);
    send_item(ActInsert, 32'sh7fff_ffff);
    send_item(ActInsert, 32'sh8000_0000);
    send_item(ActInsert, 32'shffff_ffff);
    send_item(ActInsert, 32'sh8000_0000);
    send_item(ActInsert, 32'sh7fff_ffff);
    send_item(ActDelete, 32'sh0000_0005);
    send_item(ActDelete, 32'sh8000_0000);
    send_item(ActDelete, 32'sh7fff_ffff);
    send_item(ActDelete, 32'sh0000_0000);
    send_item(ActDelete, 32'shffff_ffff);
    send_item(ActDelete, 32'sh8000_0000);
    send_item(ActDelete, 32'sh7fff_ffff);
    send_item(ActDelete, 32'sh8000_0000);
    wait_drained();

    run_phase(150, 85, 75);
    // receiver holds off while transfers keep coming, so the input stalls
    rx_hold = 80;
    run_phase(12, 100, 50);
    run_phase(150, 15, 90);
    wait_drained();
    idle_en = 1'b0;
    run_phase(150, 50, 80);
    idle_en = 1'b1;
    run_phase(150, 80, 75);
    run_phase(200, 20, 90);
    wait_drained();
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
